// File: hdl/fifo_page_frame_replacer_assert.svh
// assertion macros for the page frame replacer datapath
`ifndef FIFO_PAGE_FRAME_REPLACER_ASSERT_SVH
`define FIFO_PAGE_FRAME_REPLACER_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define FPFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpfr assertion failed");

// next-cycle implication
`define FPFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpfr assertion failed");

`endif

// File: hdl/fpfr_pkg.sv
// shared constants and controller/datapath interface types
package fpfr_pkg;

  localparam int DEF_NUM_FRAMES = 64;
  localparam int DEF_PROC_BITS  = 8;
  localparam int DEF_PAGE_BITS  = 20;

  typedef struct packed {
    logic init_wr;
    logic start;
    logic clr_r;
    logic step;
    logic hit;
    logic alloc;
    logic evict;
    logic rel;
    logic rel_end;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic empty;
    logic last;
    logic match;
    logic own_match;
    logic full;
    logic fin;
    logic out_busy;
  } sts_t;

endpackage

// File: hdl/fifo_page_frame_replacer.sv
// fifo page frame replacer: lookup, fifo replacement and release on termination
// sequence: the lookup reads the resident frames in turn (a hit stops the scan),
//   then a fault fills a free frame or evicts the oldest; a final reference walks
//   every resident frame to release the owner's frames; then the result is registered
// requests: one at a time, the next taken in the cycle after the result loads;
//   the resident-queue ram has a single read port
// reset: synchronous, active low; the free queue is then filled, tready low
module fifo_page_frame_replacer #(
  parameter int NUM_FRAMES = fpfr_pkg::DEF_NUM_FRAMES,
  parameter int PROC_BITS  = fpfr_pkg::DEF_PROC_BITS,
  parameter int PAGE_BITS  = fpfr_pkg::DEF_PAGE_BITS,
  localparam int CNT_W     = $clog2(NUM_FRAMES + 1),
  localparam int IN_W      = ((PROC_BITS + PAGE_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((2 * CNT_W + PROC_BITS + PAGE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // request: proc_id, virt_page (lowest bit first)
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tlast,   // final_ref
  // result: frame_no, evicted_proc, evicted_page, released_count
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic [1:0]       out_tuser   // hit, evicted
);

  fpfr_pkg::cmd_t cmd;
  fpfr_pkg::sts_t sts;

  logic                 hit, evicted;
  logic [CNT_W-1:0]     frame_no, released_count;
  logic [PROC_BITS-1:0] evicted_proc;
  logic [PAGE_BITS-1:0] evicted_page;

  // controller only sequences; all storage sits in the datapath
  fpfr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  fpfr_dp #(
    .NUM_FRAMES(NUM_FRAMES), .PROC_BITS(PROC_BITS), .PAGE_BITS(PAGE_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .sts(sts),
    .in_proc_id(in_tdata[PROC_BITS-1:0]),
    .in_virt_page(in_tdata[PROC_BITS +: PAGE_BITS]),
    .in_final_ref(in_tlast),
    .out_tready(out_tready),
    .out_valid(out_tvalid),
    .out_hit(hit),
    .out_frame_no(frame_no),
    .out_evicted(evicted),
    .out_evicted_proc(evicted_proc),
    .out_evicted_page(evicted_page),
    .out_released_count(released_count)
  );

  // pack result fields, first field lowest, zero padded to whole bytes
  assign out_tdata = OUT_W'({released_count, evicted_page, evicted_proc, frame_no});
  assign out_tuser = {evicted, hit};

endmodule

// File: hdl/fpfr_ram.sv
// generic single write port ram with registered read
module fpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/fpfr_ctrl.sv
// sequencing state machine for lookup, allocation, eviction and release
module fpfr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  fpfr_pkg::sts_t sts,
  output fpfr_pkg::cmd_t cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LREAD = 4'd2;
  localparam logic [3:0] S_LCHK  = 4'd3;
  localparam logic [3:0] S_MISS  = 4'd4;
  localparam logic [3:0] S_EVRD  = 4'd5;
  localparam logic [3:0] S_EVICT = 4'd6;
  localparam logic [3:0] S_ALLOC = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_RREAD = 4'd9;
  localparam logic [3:0] S_RCHK  = 4'd10;
  localparam logic [3:0] S_REND  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        cmd.step    = 1'b1;
        if (sts.init_last) begin
          cmd.clr_r = 1'b1;
          cmd.step  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = sts.empty ? S_MISS : S_LREAD;
        end
      end
      S_LREAD: state_nxt = S_LCHK;
      S_LCHK: begin
        if (sts.match) begin
          cmd.hit   = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.last) begin
          state_nxt = S_MISS;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_LREAD;
        end
      end
      S_MISS: begin
        cmd.clr_r = 1'b1;
        state_nxt = sts.full ? S_EVRD : S_ALLOC;
      end
      S_EVRD: state_nxt = S_EVICT;
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = S_FIN;
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.clr_r = 1'b1;
        state_nxt = sts.fin ? S_RREAD : S_DONE;
      end
      S_RREAD: state_nxt = S_RCHK;
      S_RCHK: begin
        cmd.rel   = 1'b1;
        state_nxt = sts.last ? S_REND : S_RREAD;
      end
      S_REND: begin
        cmd.rel_end = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/fpfr_dp.sv
// datapath: resident and free frame queues, pointers, counters, result register
module fpfr_dp #(
  parameter int NUM_FRAMES = fpfr_pkg::DEF_NUM_FRAMES,
  parameter int PROC_BITS  = fpfr_pkg::DEF_PROC_BITS,
  parameter int PAGE_BITS  = fpfr_pkg::DEF_PAGE_BITS,
  localparam int IDX_W     = $clog2(NUM_FRAMES),
  localparam int CNT_W     = $clog2(NUM_FRAMES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fpfr_pkg::cmd_t       cmd,
  output fpfr_pkg::sts_t       sts,
  input  logic [PROC_BITS-1:0] in_proc_id,
  input  logic [PAGE_BITS-1:0] in_virt_page,
  input  logic                 in_final_ref,
  input  logic                 out_tready,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [CNT_W-1:0]     out_frame_no,
  output logic                 out_evicted,
  output logic [PROC_BITS-1:0] out_evicted_proc,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [CNT_W-1:0]     out_released_count
);

  localparam int ENT_W = IDX_W + PROC_BITS + PAGE_BITS;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(NUM_FRAMES)) begin
      s = s - (CNT_W+1)'(NUM_FRAMES);
    end
    return s[IDX_W-1:0];
  endfunction

  logic [PROC_BITS-1:0] proc_r;
  logic [PAGE_BITS-1:0] page_r;
  logic                 fin_r;
  logic [IDX_W-1:0]     r_r, res_head_r, free_head_r;
  logic [CNT_W-1:0]     kept_r, res_cnt_r, free_cnt_r, freed_r;
  logic                 hit_r, ev_r;
  logic [IDX_W-1:0]     frame_r;
  logic [PROC_BITS-1:0] evp_r;
  logic [PAGE_BITS-1:0] evg_r;
  logic                 out_valid_r;

  logic                 res_we, free_we;
  logic [IDX_W-1:0]     res_waddr, free_waddr, res_raddr;
  logic [ENT_W-1:0]     res_wdata, res_rdata;
  logic [IDX_W-1:0]     free_wdata, free_rdata;
  logic [IDX_W-1:0]     rd_frame;
  logic [PROC_BITS-1:0] rd_owner;
  logic [PAGE_BITS-1:0] rd_page;
  logic [CNT_W:0]       frames_total;

  assign rd_frame  = res_rdata[IDX_W-1:0];
  assign rd_owner  = res_rdata[IDX_W +: PROC_BITS];
  assign rd_page   = res_rdata[IDX_W+PROC_BITS +: PAGE_BITS];
  assign res_raddr = wrap_add(res_head_r, CNT_W'(r_r));

  // resident queue entries are {page, owner, frame}, oldest at the head
  fpfr_ram #(.WIDTH(ENT_W), .DEPTH(NUM_FRAMES)) u_res_ram (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(res_raddr), .rdata(res_rdata)
  );

  fpfr_ram #(.WIDTH(IDX_W), .DEPTH(NUM_FRAMES)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(free_head_r), .rdata(free_rdata)
  );

  always_comb begin
    res_we    = 1'b0;
    res_waddr = res_head_r;
    res_wdata = res_rdata;
    if (cmd.alloc) begin
      res_we    = 1'b1;
      res_waddr = wrap_add(res_head_r, res_cnt_r);
      res_wdata = {page_r, proc_r, free_rdata};
    end else if (cmd.evict) begin
      res_we    = 1'b1;
      res_wdata = {page_r, proc_r, rd_frame};
    end else if (cmd.rel && !sts.own_match) begin
      res_we    = 1'b1;
      res_waddr = wrap_add(res_head_r, kept_r);
    end
  end

  always_comb begin
    free_we    = 1'b0;
    free_waddr = r_r;
    free_wdata = r_r;
    if (cmd.init_wr) begin
      free_we = 1'b1;
    end else if (cmd.rel && sts.own_match) begin
      free_we    = 1'b1;
      free_waddr = wrap_add(free_head_r, free_cnt_r);
      free_wdata = rd_frame;
    end
  end

  always_comb begin
    sts.init_last = (r_r == IDX_W'(NUM_FRAMES - 1));
    sts.empty     = (res_cnt_r == '0);
    sts.last      = ((CNT_W'(r_r) + CNT_W'(1)) == res_cnt_r);
    sts.own_match = (rd_owner == proc_r);
    sts.match     = sts.own_match && (rd_page == page_r);
    sts.full      = (free_cnt_r == '0);
    sts.fin       = fin_r;
    sts.out_busy  = out_valid_r && !out_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      proc_r  <= in_proc_id;
      page_r  <= in_virt_page;
      fin_r   <= in_final_ref;
      hit_r   <= 1'b0;
      ev_r    <= 1'b0;
      evp_r   <= '0;
      evg_r   <= '0;
      frame_r <= '0;
    end
    if (cmd.hit) begin
      hit_r   <= 1'b1;
      frame_r <= rd_frame;
    end
    if (cmd.alloc) begin
      frame_r <= free_rdata;
    end
    if (cmd.evict) begin
      ev_r    <= 1'b1;
      evp_r   <= rd_owner;
      evg_r   <= rd_page;
      frame_r <= rd_frame;
    end
    if (cmd.out_load) begin
      out_hit            <= hit_r;
      out_frame_no       <= CNT_W'(frame_r) + CNT_W'(1);
      out_evicted        <= ev_r;
      out_evicted_proc   <= evp_r;
      out_evicted_page   <= evg_r;
      out_released_count <= freed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r         <= '0;
      kept_r      <= '0;
      freed_r     <= '0;
      res_head_r  <= '0;
      res_cnt_r   <= '0;
      free_head_r <= '0;
      free_cnt_r  <= CNT_W'(NUM_FRAMES);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start || cmd.clr_r) begin
        r_r    <= '0;
        kept_r <= '0;
      end
      if (cmd.start) begin
        freed_r <= '0;
      end
      if (cmd.step) begin
        r_r <= r_r + IDX_W'(1);
      end
      if (cmd.alloc) begin
        res_cnt_r   <= res_cnt_r + CNT_W'(1);
        free_cnt_r  <= free_cnt_r - CNT_W'(1);
        free_head_r <= wrap_add(free_head_r, CNT_W'(1));
      end
      if (cmd.evict) begin
        res_head_r <= wrap_add(res_head_r, CNT_W'(1));
      end
      if (cmd.rel) begin
        r_r <= r_r + IDX_W'(1);
        if (sts.own_match) begin
          free_cnt_r <= free_cnt_r + CNT_W'(1);
          freed_r    <= freed_r + CNT_W'(1);
        end else begin
          kept_r <= kept_r + CNT_W'(1);
        end
      end
      if (cmd.rel_end) begin
        res_cnt_r <= kept_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  // frames held by both queues together
  assign frames_total = (CNT_W+1)'(free_cnt_r) + (CNT_W+1)'(res_cnt_r);

`include "fifo_page_frame_replacer_assert.svh"

  // a free frame must exist when allocating, none when evicting
  `FPFR_ASSERT_IMP(a_alloc_has_free, cmd.alloc, free_cnt_r != '0)
  `FPFR_ASSERT_IMP(a_evict_when_full, cmd.evict, res_cnt_r == CNT_W'(NUM_FRAMES))
  // allocation moves exactly one frame from free to resident
  `FPFR_ASSERT_NXT(a_alloc_moves_one, cmd.alloc, free_cnt_r == $past(free_cnt_r) - CNT_W'(1))
  // when a request starts, the two queues together hold every frame
  `FPFR_ASSERT_IMP(a_frames_conserved, cmd.start, frames_total == (CNT_W+1)'(NUM_FRAMES))

endmodule

// File: verif/tb_top.sv
// testbench for the fifo page frame replacer: directed and random requests, scoreboard check
`timescale 1ns / 1ps

module tb_top;

  localparam int NFR     = fpfr_pkg::DEF_NUM_FRAMES;
  localparam int PBITS   = fpfr_pkg::DEF_PROC_BITS;
  localparam int GBITS   = fpfr_pkg::DEF_PAGE_BITS;
  localparam int CW      = $clog2(NFR + 1);
  localparam int IW      = ((PBITS + GBITS + 7) / 8) * 8;
  localparam int OW      = ((2 * CW + PBITS + GBITS + 7) / 8) * 8;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic             hit;
    logic [CW-1:0]    frame_no;
    logic             evicted;
    logic [PBITS-1:0] ev_proc;
    logic [GBITS-1:0] ev_page;
    logic [CW-1:0]    released;
  } outcome_t;

  // predictor of the frame table plus queue of expected outcomes
  class frame_table_board;
    bit               valid[NFR];
    bit [PBITS-1:0]   owner[NFR];
    bit [GBITS-1:0]   page[NFR];
    int               rank[NFR];
    int               freeq[NFR];
    int               head, nfree, nres;
    outcome_t         pending[$];
    int               errors;

    function void clear();
      for (int i = 0; i < NFR; i++) begin
        valid[i] = 0;
        freeq[i] = i;
      end
      head = 0; nfree = NFR; nres = 0; errors = 0;
    endfunction

    function int frame_of_rank(int r);
      for (int f = 0; f < NFR; f++)
        if (valid[f] && rank[f] == r) return f;
      return -1;
    endfunction

    // note an accepted request and work out its outcome
    function void note_request(bit [PBITS-1:0] p, bit [GBITS-1:0] g, bit fin);
      outcome_t o;
      int fr, kept, oldn, f;
      o = '0;
      fr = -1;
      for (int i = 0; i < NFR; i++)
        if (valid[i] && owner[i] == p && page[i] == g) begin
          fr = i;
          break;
        end
      if (fr >= 0) o.hit = 1;
      else if (nfree > 0) begin
        fr = freeq[head];
        head = (head + 1) % NFR;
        nfree--;
        valid[fr] = 1; owner[fr] = p; page[fr] = g; rank[fr] = nres;
        nres++;
      end else begin
        fr = frame_of_rank(0);
        o.evicted = 1;
        o.ev_proc = owner[fr];
        o.ev_page = page[fr];
        for (int i = 0; i < NFR; i++)
          if (valid[i] && rank[i] > 0) rank[i]--;
        owner[fr] = p; page[fr] = g; rank[fr] = nres - 1;
      end
      o.frame_no = CW'(fr + 1);
      if (fin) begin
        // release walk, oldest first
        kept = 0;
        oldn = nres;
        for (int r = 0; r < oldn; r++) begin
          f = frame_of_rank(r);
          if (f < 0) continue;
          if (owner[f] == p) begin
            freeq[(head + nfree) % NFR] = f;
            nfree++;
            valid[f] = 0;
            o.released++;
          end else begin
            rank[f] = kept++;
          end
        end
        nres = kept;
      end
      pending.push_back(o);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(outcome_t got);
      outcome_t e;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.hit != e.hit) report($sformatf("hit %0d want %0d", got.hit, e.hit));
      if (got.frame_no != e.frame_no)
        report($sformatf("frame %0d want %0d", got.frame_no, e.frame_no));
      if (got.evicted != e.evicted)
        report($sformatf("evicted %0d want %0d", got.evicted, e.evicted));
      if (got.ev_proc != e.ev_proc)
        report($sformatf("evicted proc %0h want %0h", got.ev_proc, e.ev_proc));
      if (got.ev_page != e.ev_page)
        report($sformatf("evicted page %0h want %0h", got.ev_page, e.ev_page));
      if (got.released != e.released)
        report($sformatf("released %0d want %0d", got.released, e.released));
    endtask
  endclass

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_tvalid = 0;
  logic          in_tready;
  logic [IW-1:0] in_tdata = '0;   // proc_id, virt_page
  logic          in_tlast = 0;    // final_ref
  logic          out_tvalid;
  logic          out_tready = 0;
  logic [OW-1:0] out_tdata;       // frame_no, evicted_proc, evicted_page, released_count
  logic [1:0]    out_tuser;       // hit, evicted

  frame_table_board board = new();
  bit    rx_hold = 0;        // long stall of the receiver
  bit    no_idle = 0;        // stretch with no random idling
  int    quiet = 0;

  always #6 clk = ~clk;

  fifo_page_frame_replacer dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  // offer one request, keeping tvalid high until it is taken
  task automatic send_request(bit [PBITS-1:0] p, bit [GBITS-1:0] g, bit fin);
    while (!no_idle && $urandom_range(99) < 18) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= IW'({g, p});
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    board.note_request(p, g, fin);
  endtask

  task automatic idle_input();
    in_tvalid <= 0;
  endtask

  // receiver: random stall, plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      out_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 18);
      if (out_tvalid && out_tready)
        board.check_result({out_tuser[0], out_tdata[CW-1:0], out_tuser[1],
                            out_tdata[CW+PBITS-1:CW],
                            out_tdata[CW+PBITS+GBITS-1:CW+PBITS],
                            out_tdata[2*CW+PBITS+GBITS-1:CW+PBITS+GBITS]});
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hold the receiver off for a long stretch while requests keep coming
  task automatic long_hold();
    rx_hold = 1;
    repeat (300) @(posedge clk);
    rx_hold = 0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    bit [PBITS-1:0] p;
    bit [GBITS-1:0] g;
    board.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed: field extremes, hit, fill, eviction, final after fault, release by a new process
    send_request('0, '0, 0);
    send_request('0, '0, 0);                 // hit
    send_request('1, '1, 0);
    send_request('1, '1, 0);                 // hit on all-ones
    send_request(8'h55, 20'hAAAAA, 0);
    send_request(8'hAA, 20'h55555, 1);       // fault then release of the new frame
    send_request(8'h77, 20'h1, 1);           // final ref releases the one just loaded
    for (int i = 0; i < NFR + 4; i++)        // fill table, then evict the oldest
      send_request(PBITS'(8'h10 + i % 3), 20'(i), 0);
    send_request(8'h11, 20'd5000, 1);        // release many frames
    send_request(8'hEE, 20'h12345, 1);       // nothing held
    wait_drained();                          // sender pauses until all results are in

    // random: small working sets so hits, evictions and releases all occur
    fork
      begin
        repeat (150) @(posedge clk);
        long_hold();
      end
    join_none
    for (int n = 0; n < 620; n++) begin
      no_idle = (n >= 300 && n < 380);
      if ($urandom_range(9) == 0) begin
        p = PBITS'($urandom); g = GBITS'($urandom);
      end else begin
        p = PBITS'($urandom_range(7) | ($urandom_range(1) ? 8'hF8 : 8'h00));
        g = GBITS'($urandom_range(90) | ($urandom_range(1) ? 20'hFFF00 : 20'h0));
      end
      send_request(p, g, $urandom_range(29) == 0);
    end
    no_idle = 0;
    wait_drained();
    repeat (300) @(posedge clk);

    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// File: files.f
+incdir+hdl
hdl/fpfr_pkg.sv
hdl/fpfr_ram.sv
hdl/fpfr_ctrl.sv
hdl/fpfr_dp.sv
hdl/fifo_page_frame_replacer.sv
verif/tb_top.sv
